### rtl/core/hpe_pkg.sv
// Shared constants, types and a helper function for the haplotype pair enumerator.
package hpe_pkg;

  localparam int MAX_LOCI = 8;
  localparam int MAX_ALLELES = 16;
  localparam int LOCUS_W = 3;
  localparam int ALLELE_W = 5;
  localparam int DIGIT_W = 4;
  localparam int NLOCI_W = 4;
  localparam int CODE_W = 32;
  localparam int SWAP_W = 8;
  localparam int HET_W = 4;

  localparam logic REG_NUM_LOCI = 1'b0;
  localparam logic REG_DIPLOID = 1'b1;

  typedef enum logic [2:0] {
    MAC_HOLD,
    MAC_CLEAR,
    MAC_ACC0,
    MAC_ACC1,
    MAC_SCALE
  } mac_op_t;

  typedef struct packed {
    mac_op_t op;
    logic [ALLELE_W-1:0] coef;
  } mac_cmd_t;

  function automatic logic [ALLELE_W-1:0] radix_of(input logic [ALLELE_W-1:0] c);
    logic [ALLELE_W-1:0] r;
    r = c;
    if (c == '0) begin
      r = ALLELE_W'(1);
    end else if (c > ALLELE_W'(MAX_ALLELES)) begin
      r = ALLELE_W'(MAX_ALLELES);
    end
    return r;
  endfunction

endpackage

### rtl/core/haplotype_pair_enumerator.sv
// Top level of the haplotype pair enumerator: locus store, sequencer and counters.
// A load item is written when accepted and produces no result; busy stays low.
// A request on an exhausted enumeration answers on the cycle after it is accepted.
// Any other request walks the n loci in use, highest first, then raises done;
// the single multiply unit serves three steps per locus; busy is high meanwhile.
// Synchronous reset clears the counters and digits; the locus store holds no reset.
module haplotype_pair_enumerator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            req_type,
  input  logic [hpe_pkg::LOCUS_W-1:0]     locus_index,
  input  logic [hpe_pkg::ALLELE_W-1:0]    allele_count,
  input  logic [hpe_pkg::ALLELE_W-1:0]    allele_first,
  input  logic [hpe_pkg::ALLELE_W-1:0]    allele_second,
  input  logic                            wr_en,
  input  logic                            wr_index,
  input  logic [hpe_pkg::NLOCI_W-1:0]     wr_data,
  output logic                            done,
  output logic [hpe_pkg::CODE_W-1:0]      first_code,
  output logic signed [hpe_pkg::CODE_W:0] second_code,
  output logic                            last_flag,
  output logic                            status
);
  import hpe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOCUS,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_CODE0,
    PH_CODE1,
    PH_ADVANCE
  } phase_t;

  state_t state;
  phase_t phase;

  logic [NLOCI_W-1:0] num_loci;
  logic diploid_mode;

  logic [ALLELE_W-1:0] count_mem [MAX_LOCI];
  logic [ALLELE_W-1:0] allele0_mem [MAX_LOCI];
  logic [ALLELE_W-1:0] allele1_mem [MAX_LOCI];
  logic [DIGIT_W-1:0] dig0 [MAX_LOCI];
  logic [DIGIT_W-1:0] dig1 [MAX_LOCI];

  logic [SWAP_W-1:0] swap_counter;
  logic exhausted;
  logic [LOCUS_W-1:0] locus;
  logic carry;
  logic [HET_W-1:0] het_seen;

  logic accept;
  logic [NLOCI_W-1:0] n_use;
  logic [NLOCI_W-1:0] n_use_m1;
  logic [ALLELE_W-1:0] a0;
  logic [ALLELE_W-1:0] a1;
  logic [ALLELE_W-1:0] radix;
  logic missing;
  logic het;
  logic swap_bit;
  logic [ALLELE_W-1:0] h0;
  logic [ALLELE_W-1:0] h1;
  logic [ALLELE_W-1:0] d0_inc;
  logic [ALLELE_W-1:0] d1_inc;
  logic d0_wrap;
  logic d1_wrap;
  logic [DIGIT_W-1:0] d0_next;
  logic [DIGIT_W-1:0] d1_next;
  logic [SWAP_W:0] swap_inc;
  logic [SWAP_W:0] het_limit;
  logic can_swap;
  mac_cmd_t mac_cmd;
  logic [CODE_W-1:0] acc0;
  logic [CODE_W-1:0] acc1;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    n_use = num_loci;
    if (num_loci == '0) begin
      n_use = NLOCI_W'(1);
    end else if (num_loci > NLOCI_W'(MAX_LOCI)) begin
      n_use = NLOCI_W'(MAX_LOCI);
    end
  end
  assign n_use_m1 = n_use - NLOCI_W'(1);

  assign a0 = allele0_mem[locus];
  assign a1 = allele1_mem[locus];
  assign radix = radix_of(count_mem[locus]);
  assign missing = diploid_mode ? ((a0 == '0) || (a1 == '0)) : (a0 == '0);
  assign het = diploid_mode && !missing && (a0 != a1);
  assign swap_bit = swap_counter[het_seen[LOCUS_W-1:0]];

  assign d0_inc = {1'b0, dig0[locus]} + ALLELE_W'(1);
  assign d1_inc = {1'b0, dig1[locus]} + ALLELE_W'(1);
  assign d0_wrap = (d0_inc >= radix);
  assign d1_wrap = (d1_inc >= radix);
  assign d0_next = d0_wrap ? '0 : d0_inc[DIGIT_W-1:0];
  assign d1_next = d1_wrap ? '0 : d1_inc[DIGIT_W-1:0];

  always_comb begin
    if (missing) begin
      h0 = d0_inc;
      h1 = d1_inc;
    end else if (het && swap_bit) begin
      h0 = a1;
      h1 = a0;
    end else begin
      h0 = a0;
      h1 = a1;
    end
  end

  assign swap_inc = {1'b0, swap_counter} + (SWAP_W+1)'(1);
  assign het_limit = (SWAP_W+1)'(1) << het_seen;
  assign can_swap = diploid_mode && (swap_inc < het_limit);

  always_comb begin
    mac_cmd.op = MAC_HOLD;
    mac_cmd.coef = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && req_type && !exhausted) begin
          mac_cmd.op = MAC_CLEAR;
        end
      end
      S_LOCUS: begin
        unique case (phase)
          PH_CODE0: begin
            mac_cmd.op = MAC_ACC0;
            mac_cmd.coef = h0 - ALLELE_W'(1);
          end
          PH_CODE1: begin
            mac_cmd.op = MAC_ACC1;
            mac_cmd.coef = h1 - ALLELE_W'(1);
          end
          PH_ADVANCE: begin
            mac_cmd.op = MAC_SCALE;
            mac_cmd.coef = radix;
          end
          default: begin
          end
        endcase
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  hpe_mac u_mac (
    .clk  (clk),
    .cmd  (mac_cmd),
    .acc0 (acc0),
    .acc1 (acc1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_CODE0;
      done <= 1'b0;
      status <= 1'b0;
      last_flag <= 1'b0;
      num_loci <= NLOCI_W'(1);
      diploid_mode <= 1'b1;
      swap_counter <= '0;
      exhausted <= 1'b0;
      carry <= 1'b0;
      het_seen <= '0;
      locus <= '0;
      for (int k = 0; k < MAX_LOCI; k++) begin
        dig0[k] <= '0;
        dig1[k] <= '0;
      end
    end else begin
      done <= 1'b0;

      if (wr_en) begin
        unique case (wr_index)
          REG_NUM_LOCI: num_loci <= wr_data;
          REG_DIPLOID: diploid_mode <= wr_data[0];
        endcase
        swap_counter <= '0;
        exhausted <= 1'b0;
        for (int k = 0; k < MAX_LOCI; k++) begin
          dig0[k] <= '0;
          dig1[k] <= '0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!req_type) begin
              count_mem[locus_index] <= allele_count;
              allele0_mem[locus_index] <= allele_first;
              allele1_mem[locus_index] <= allele_second;
              swap_counter <= '0;
              exhausted <= 1'b0;
              for (int k = 0; k < MAX_LOCI; k++) begin
                dig0[k] <= '0;
                dig1[k] <= '0;
              end
            end else if (exhausted) begin
              done <= 1'b1;
              status <= 1'b1;
              last_flag <= 1'b0;
              first_code <= '0;
              second_code <= '0;
            end else begin
              state <= S_LOCUS;
              phase <= PH_CODE0;
              locus <= n_use_m1[LOCUS_W-1:0];
              carry <= 1'b1;
              het_seen <= '0;
            end
          end
        end
        S_LOCUS: begin
          unique case (phase)
            PH_CODE0: phase <= PH_CODE1;
            PH_CODE1: phase <= PH_ADVANCE;
            PH_ADVANCE: begin
              phase <= PH_CODE0;
              if (het) begin
                het_seen <= het_seen + HET_W'(1);
              end
              if (missing && carry) begin
                if (diploid_mode) begin
                  dig1[locus] <= d1_next;
                  if (d1_wrap) begin
                    dig0[locus] <= d0_next;
                  end
                  carry <= d1_wrap && d0_wrap;
                end else begin
                  dig0[locus] <= d0_next;
                  carry <= d0_wrap;
                end
              end
              if (locus == '0) begin
                state <= S_FINISH;
              end else begin
                locus <= locus - LOCUS_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
        S_FINISH: begin
          state <= S_IDLE;
          done <= 1'b1;
          status <= 1'b0;
          first_code <= acc0;
          second_code <= diploid_mode ? {1'b0, acc1} : '1;
          last_flag <= 1'b0;
          if (carry) begin
            if (can_swap) begin
              swap_counter <= swap_inc[SWAP_W-1:0];
            end else begin
              exhausted <= 1'b1;
              last_flag <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/hpe_mac.sv
// Shared multiply unit that builds place values and accumulates both haplotype codes.
module hpe_mac (
  input  logic                          clk,
  input  hpe_pkg::mac_cmd_t             cmd,
  output logic [hpe_pkg::CODE_W-1:0]    acc0,
  output logic [hpe_pkg::CODE_W-1:0]    acc1
);
  import hpe_pkg::*;

  logic [CODE_W-1:0] place;
  logic [CODE_W+ALLELE_W-1:0] prod;

  assign prod = {{ALLELE_W{1'b0}}, place} * {{CODE_W{1'b0}}, cmd.coef};

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      MAC_HOLD: begin
      end
      MAC_CLEAR: begin
        place <= CODE_W'(1);
        acc0 <= '0;
        acc1 <= '0;
      end
      MAC_ACC0: begin
        acc0 <= acc0 + prod[CODE_W-1:0];
      end
      MAC_ACC1: begin
        acc1 <= acc1 + prod[CODE_W-1:0];
      end
      MAC_SCALE: begin
        place <= prod[CODE_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule
